### hdl/sacvb_pkg.sv
// Package for the set-associative cache with victim buffer.
// Holds payload structs, register indexes and outcome codes; no dependencies.
`timescale 1ns / 1ps
package sacvb_pkg;
  typedef struct packed {
    logic        command;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        victim_probed;
    logic        fetch_valid;
    logic        writeback_valid;
    logic [31:0] writeback_address;
  } out_item_t;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_INDEX  = 2'd1;
  localparam logic [1:0] REG_WAYS   = 2'd2;
  localparam logic [1:0] REG_VICTIM = 2'd3;

  localparam logic [1:0] OUT_HIT    = 2'd0;
  localparam logic [1:0] OUT_VHIT   = 2'd1;
  localparam logic [1:0] OUT_MISS   = 2'd2;

  typedef struct packed {
    logic        wr;
    logic [7:0]  set;
    logic [30:0] tag;
  } req_t;

  typedef struct packed {
    logic [7:0]       lv;
    logic [7:0]       ld;
    logic [7:0][2:0]  lr;
    logic [7:0][30:0] tags;
  } row_t;
endpackage

### hdl/sacvb_front.sv
// Front end: accepts transactions, splits the address into set and tag.
// Depends on sacvb_pkg; feeds a two-entry queue toward the back end.
`timescale 1ns / 1ps
module sacvb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sacvb_pkg::in_item_t in_data,
  input  logic [3:0]         ob,
  input  logic [3:0]         ib,
  output logic               q_valid,
  input  logic               q_ready,
  output sacvb_pkg::req_t    q_data
);
  sacvb_pkg::req_t q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wp_r;
  logic [31:0] sh;
  sacvb_pkg::req_t rq;
  logic push, pop;

  always_comb begin
    sh = in_data.address >> ob;
    rq.wr  = in_data.command;
    rq.set = sh[7:0] & 8'((9'd1 << ib) - 9'd1);
    rq.tag = 31'(sh >> ib);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_r[rd_r];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) q_r[wp_r] <= rq;
  end
endmodule

### hdl/sacvb_back.sv
// Back end: set read, lookup, victim probe, replacement and update sequencer.
// Depends on sacvb_pkg; set rows live in one memory, victim entries in flip-flops.
`timescale 1ns / 1ps
module sacvb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  sacvb_pkg::req_t    q_data,
  input  logic [3:0]         ob,
  input  logic [3:0]         ib,
  input  logic [3:0]         ways,
  input  logic [4:0]         nv,
  output logic               out_valid,
  input  logic               out_ready,
  output sacvb_pkg::out_item_t out_data
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] st_r;
  sacvb_pkg::req_t req_r;
  sacvb_pkg::row_t row_mem [256];
  sacvb_pkg::row_t row_r, row_nxt, wr_row;
  logic        clr_busy_r;
  logic [7:0]  clr_idx_r;
  logic        mem_we;
  logic [7:0]  mem_addr;
  logic [15:0] sv_r, sd_r;
  logic [30:0] st_tag_r [16];
  logic [7:0]  ss_r [16];
  logic [3:0]  sr_r [16];
  sacvb_pkg::out_item_t res_r, pend_r;
  logic        res_v_r;

  // Execute-stage combinational decision.
  logic [7:0] act, lv, ld;
  logic [2:0] lr [8];
  logic [30:0] tags [8];
  logic hit, full, found, vhit, spill, sfound, wb;
  logic [2:0] hw, pw, fw, cnt;
  logic [3:0] vi, si;
  logic [2:0] best;
  logic [7:0] ev_set;
  logic [30:0] ev_tag;
  logic ev_d;
  logic [31:0] wba;

  always_comb begin
    lv = row_r.lv;
    ld = row_r.ld;
    for (int w = 0; w < 8; w++) begin
      lr[w] = row_r.lr[w];
      tags[w] = row_r.tags[w];
      act[w] = (4'(w) < ways);
    end
    hit = 1'b0; hw = '0; full = 1'b1;
    for (int w = 7; w >= 0; w--) begin
      if (act[w] && lv[w] && tags[w] == req_r.tag) begin
        hit = 1'b1; hw = 3'(w);
      end
      if (act[w] && !lv[w]) full = 1'b0;
    end
    found = 1'b0; pw = '0;
    for (int w = 7; w >= 0; w--)
      if (act[w] && {1'b0, lr[w]} == ways - 4'd1) begin
        found = 1'b1; pw = 3'(w);
      end
    best = lr[0];
    if (!found) begin
      pw = '0;
      for (int w = 1; w < 8; w++)
        if (act[w] && lr[w] > best) begin
          best = lr[w]; pw = 3'(w);
        end
    end
    vhit = 1'b0; vi = '0;
    for (int i = 15; i >= 0; i--)
      if (5'(i) < nv && sv_r[i] && st_tag_r[i] == req_r.tag && ss_r[i] == req_r.set) begin
        vhit = 1'b1; vi = 4'(i);
      end
    sfound = 1'b0; si = '0;
    for (int i = 15; i >= 0; i--)
      if (5'(i) < nv && (!sv_r[i] || {1'b0, sr_r[i]} == nv - 5'd1)) begin
        sfound = 1'b1; si = 4'(i);
      end
    vhit  = vhit && full && (nv != 0) && !hit;
    spill = full && (nv != 0) && !hit && !vhit && sfound;
    if (spill) begin
      ev_d = sd_r[si]; ev_tag = st_tag_r[si]; ev_set = ss_r[si];
    end else begin
      ev_d = ld[pw]; ev_tag = tags[pw]; ev_set = req_r.set;
    end
    if (spill && !sv_r[si]) ev_d = 1'b0;
    wb = full && !hit && !vhit && ev_d;
    wba = 32'(((64'(ev_tag) << ib) | 64'(ev_set & 8'((9'd1 << ib) - 9'd1))) << ob);
    cnt = '0;
    for (int w = 0; w < 8; w++)
      if (act[w] && lv[w] && !(full && 3'(w) == pw)) cnt = cnt + 3'd1;
    fw = '0;
    for (int w = 7; w >= 0; w--)
      if (act[w] && (!lv[w] || (full && 3'(w) == pw))) fw = 3'(w);

    row_nxt = row_r;
    if (hit) begin
      for (int w = 0; w < 8; w++)
        if (act[w] && lv[w] && lr[w] < lr[hw]) row_nxt.lr[w] = lr[w] + 3'd1;
      row_nxt.lr[hw] = '0;
      if (req_r.wr) row_nxt.ld[hw] = 1'b1;
    end else if (vhit) begin
      row_nxt.ld[pw] = sd_r[vi] | req_r.wr;
      row_nxt.tags[pw] = st_tag_r[vi];
      for (int w = 0; w < 8; w++)
        if (act[w] && lv[w] && lr[w] < lr[pw]) row_nxt.lr[w] = lr[w] + 3'd1;
      row_nxt.lr[pw] = '0;
    end else begin
      row_nxt.lv[fw] = 1'b1;
      row_nxt.ld[fw] = req_r.wr;
      row_nxt.tags[fw] = req_r.tag;
      for (int w = 0; w < 8; w++)
        if (act[w] && lv[w] && !(full && 3'(w) == pw) && lr[w] < cnt)
          row_nxt.lr[w] = lr[w] + 3'd1;
      row_nxt.lr[fw] = '0;
    end
  end

  assign q_ready   = (st_r == S_IDLE) && !clr_busy_r;
  assign out_valid = res_v_r;
  assign out_data  = res_r;

  assign mem_we   = clr_busy_r || (st_r == S_EXEC);
  assign mem_addr = clr_busy_r ? clr_idx_r : req_r.set;
  assign wr_row   = clr_busy_r ? '0 : row_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      res_v_r <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_idx_r <= '0;
      sv_r <= '0;
      sd_r <= '0;
      for (int i = 0; i < 16; i++) sr_r[i] <= 4'(i);
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 8'd1;
        if (clr_idx_r == 8'd255) clr_busy_r <= 1'b0;
      end
      if (st_r == S_OUT && (!res_v_r || out_ready)) res_v_r <= 1'b1;
      else if (out_ready) res_v_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid && !clr_busy_r) begin
          req_r <= q_data;
          st_r <= S_READ;
        end
        S_READ: st_r <= S_EXEC;
        S_EXEC: begin
          pend_r.victim_probed <= full && !hit && (nv != 0);
          pend_r.fetch_valid <= !hit && !vhit;
          pend_r.writeback_valid <= wb;
          pend_r.writeback_address <= wb ? wba : '0;
          if (hit) begin
            pend_r.outcome <= sacvb_pkg::OUT_HIT;
          end else if (vhit) begin
            pend_r.outcome <= sacvb_pkg::OUT_VHIT;
            sv_r[vi] <= lv[pw]; sd_r[vi] <= ld[pw];
            st_tag_r[vi] <= tags[pw]; ss_r[vi] <= req_r.set;
            for (int i = 0; i < 16; i++)
              if (5'(i) < nv && sr_r[i] < sr_r[vi]) sr_r[i] <= sr_r[i] + 4'd1;
            sr_r[vi] <= '0;
          end else begin
            pend_r.outcome <= sacvb_pkg::OUT_MISS;
            if (spill) begin
              sv_r[si] <= 1'b1; sd_r[si] <= ld[pw];
              st_tag_r[si] <= tags[pw]; ss_r[si] <= req_r.set;
              for (int i = 0; i < 16; i++)
                if (5'(i) < nv && sr_r[i] < sr_r[si]) sr_r[i] <= sr_r[i] + 4'd1;
              sr_r[si] <= '0;
            end
          end
          st_r <= S_OUT;
        end
        S_OUT: if (!res_v_r || out_ready) begin
          res_r <= pend_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) row_mem[mem_addr] <= wr_row;
    if (st_r == S_READ) row_r <= row_mem[req_r.set];
  end
endmodule

### hdl/set_assoc_cache_with_victim_buffer_top.sv
// Set-associative write-back cache (tags only) with victim buffer.
// Sequence: the back end moves each transaction through its read, execute and output states;
// it takes no new transaction until the result is registered, and a busy sink stalls it.
// Reset: synchronous; registers return to 5, 8, 8 and 0, then a pass over all 256
// set rows clears the set memory before the back end takes its first transaction.
// Depends on sacvb_pkg, sacvb_front and sacvb_back.
`timescale 1ns / 1ps
module set_assoc_cache_with_victim_buffer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sacvb_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sacvb_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [4:0]           cfg_wdata
);
  logic [3:0] ob_r, ib_r, ways_r;
  logic [4:0] nv_r;
  logic [3:0] ob, ib, ways;
  logic [4:0] nv;
  logic q_valid, q_ready;
  sacvb_pkg::req_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_r <= 4'd5; ib_r <= 4'd8; ways_r <= 4'd8; nv_r <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sacvb_pkg::REG_OFFSET: ob_r <= cfg_wdata[3:0];
        sacvb_pkg::REG_INDEX:  ib_r <= cfg_wdata[3:0];
        sacvb_pkg::REG_WAYS:   ways_r <= cfg_wdata[3:0];
        sacvb_pkg::REG_VICTIM: nv_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ob   = (ob_r < 4'd1) ? 4'd1 : ((ob_r > 4'd12) ? 4'd12 : ob_r);
  assign ib   = (ib_r > 4'd8) ? 4'd8 : ib_r;
  assign ways = (ways_r < 4'd1) ? 4'd1 : ((ways_r > 4'd8) ? 4'd8 : ways_r);
  assign nv   = (nv_r > 5'd16) ? 5'd16 : nv_r;

  sacvb_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .ob, .ib,
    .q_valid, .q_ready, .q_data
  );

  sacvb_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .ob, .ib, .ways, .nv,
    .out_valid, .out_ready, .out_data
  );

  a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.outcome == sacvb_pkg::OUT_MISS) == out_data.fetch_valid)
    else $error("fetch flag disagrees with outcome");
  a_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.writeback_valid |-> out_data.outcome == sacvb_pkg::OUT_MISS)
    else $error("writeback without miss");
  a_probe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == sacvb_pkg::OUT_VHIT |-> out_data.victim_probed)
    else $error("victim hit without probe");
endmodule

### tb/tb.sv
// Self-checking testbench for set_assoc_cache_with_victim_buffer_top.
// Holds a tag-level LRU cache predictor in a scoreboard class, drives random
// and directed accesses over several register settings; depends on sacvb_pkg.
`timescale 1ns / 1ps
module tb;
  class cache_scoreboard;
    bit        vld[2048];
    bit        drt[2048];
    bit [30:0] tg[2048];
    int        rk[2048];
    bit        sv[16];
    bit        sd[16];
    bit [30:0] st[16];
    int        ss[16];
    int        sr[16];
    int        r_off, r_idx, r_ways, r_vic;
    sacvb_pkg::out_item_t pending[$];
    int        errors;

    function new();
      for (int i = 0; i < 2048; i++) begin
        vld[i] = 0; drt[i] = 0; tg[i] = 0; rk[i] = 0;
      end
      for (int i = 0; i < 16; i++) begin
        sv[i] = 0; sd[i] = 0; st[i] = 0; ss[i] = 0; sr[i] = i;
      end
      r_off = 5; r_idx = 8; r_ways = 8; r_vic = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [4:0] val);
      case (idx)
        sacvb_pkg::REG_OFFSET: r_off = val[3:0];
        sacvb_pkg::REG_INDEX: r_idx = val[3:0];
        sacvb_pkg::REG_WAYS: r_ways = val[3:0];
        sacvb_pkg::REG_VICTIM: r_vic = val;
        default: ;
      endcase
    endfunction

    function void add_expected(sacvb_pkg::out_item_t r);
      pending = {pending, r};
    endfunction

    function void touch_line(int base, int ways, int pos);
      int r;
      r = rk[pos];
      for (int w = 0; w < ways; w++)
        if (vld[base + w] && rk[base + w] < r) rk[base + w]++;
      rk[pos] = 0;
    endfunction

    function void touch_spare(int n, int pos);
      int r;
      r = sr[pos];
      for (int i = 0; i < n; i++)
        if (sr[i] < r) sr[i]++;
      sr[pos] = 0;
    endfunction

    function int swap_entry(int ln, int sp, int set);
      bit v, d;
      bit [30:0] t;
      int s;
      v = sv[sp]; d = sd[sp]; t = st[sp]; s = ss[sp];
      sv[sp] = vld[ln]; sd[sp] = drt[ln]; st[sp] = tg[ln]; ss[sp] = set;
      vld[ln] = v; drt[ln] = d; tg[ln] = t;
      return s;
    endfunction

    function void note_access(sacvb_pkg::in_item_t it);
      int ob, ib, ways, nv, set, base, pos, cnt, best, ev_set;
      bit full, found, wr;
      bit [63:0] tag, wa;
      sacvb_pkg::out_item_t r;
      ob = (r_off < 1) ? 1 : (r_off > 12 ? 12 : r_off);
      ib = (r_idx > 8) ? 8 : r_idx;
      ways = (r_ways < 1) ? 1 : (r_ways > 8 ? 8 : r_ways);
      nv = (r_vic > 16) ? 16 : r_vic;
      wr = it.command;
      set = (it.address >> ob) & ((1 << ib) - 1);
      tag = {32'd0, it.address} >> (ob + ib);
      base = set * 8;
      pos = base;
      full = 1;
      r = '0;
      for (int w = 0; w < ways; w++) begin
        if (vld[base + w] && tg[base + w] == tag[30:0]) begin
          touch_line(base, ways, base + w);
          if (wr) drt[base + w] = 1;
          r.outcome = sacvb_pkg::OUT_HIT;
          add_expected(r);
          return;
        end
        if (!vld[base + w]) full = 0;
      end
      if (full) begin
        found = 0;
        ev_set = set;
        for (int w = 0; w < ways; w++)
          if (!found && rk[base + w] == ways - 1) begin
            pos = base + w; found = 1;
          end
        if (!found) begin
          best = 0;
          for (int w = 0; w < ways; w++)
            if (w == 0 || rk[base + w] > best) begin
              best = rk[base + w]; pos = base + w;
            end
        end
        if (nv > 0) begin
          r.victim_probed = 1;
          for (int i = 0; i < nv; i++)
            if (sv[i] && st[i] == tag[30:0] && ss[i] == set) begin
              void'(swap_entry(pos, i, set));
              touch_line(base, ways, pos);
              touch_spare(nv, i);
              if (wr) drt[pos] = 1;
              r.outcome = sacvb_pkg::OUT_VHIT;
              add_expected(r);
              return;
            end
          found = 0;
          for (int i = 0; i < nv; i++)
            if (!found && (!sv[i] || sr[i] == nv - 1)) begin
              ev_set = swap_entry(pos, i, set);
              touch_spare(nv, i);
              found = 1;
            end
        end
        if (drt[pos]) begin
          wa = (({33'd0, tg[pos]} << ib) | (ev_set & ((1 << ib) - 1))) << ob;
          r.writeback_valid = 1;
          r.writeback_address = wa[31:0];
          drt[pos] = 0;
        end
        vld[pos] = 0;
      end
      cnt = 0;
      for (int w = 0; w < ways; w++)
        if (vld[base + w]) cnt++;
      found = 0;
      for (int w = 0; w < ways; w++)
        if (!found && !vld[base + w]) begin
          vld[base + w] = 1;
          drt[base + w] = wr;
          rk[base + w] = cnt;
          tg[base + w] = tag[30:0];
          touch_line(base, ways, base + w);
          found = 1;
        end
      r.outcome = sacvb_pkg::OUT_MISS;
      r.fetch_valid = 1;
      add_expected(r);
    endfunction

    function void check_result(sacvb_pkg::out_item_t got);
      sacvb_pkg::out_item_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.outcome !== exp_r.outcome)
        $display("%0t: outcome exp %0d got %0d", $time, exp_r.outcome, got.outcome);
      if (got.victim_probed !== exp_r.victim_probed)
        $display("%0t: victim_probed exp %0d got %0d", $time, exp_r.victim_probed,
                 got.victim_probed);
      if (got.fetch_valid !== exp_r.fetch_valid)
        $display("%0t: fetch_valid exp %0d got %0d", $time, exp_r.fetch_valid,
                 got.fetch_valid);
      if (got.writeback_valid !== exp_r.writeback_valid)
        $display("%0t: writeback_valid exp %0d got %0d", $time, exp_r.writeback_valid,
                 got.writeback_valid);
      if (got.writeback_address !== exp_r.writeback_address)
        $display("%0t: writeback_address exp %h got %h", $time,
                 exp_r.writeback_address, got.writeback_address);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_valid = 0;
  logic                 in_ready;
  sacvb_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 0;
  sacvb_pkg::out_item_t out_data;
  logic                 cfg_we = 0;
  logic [1:0]           cfg_index = sacvb_pkg::REG_OFFSET;
  logic [4:0]           cfg_wdata = '0;

  cache_scoreboard sb;
  bit  idle_off = 0;
  bit  hold_sink = 0;
  bit  timed_out = 0;
  int  quiet = 0;
  bit [31:0] hot_addr[8];

  set_assoc_cache_with_victim_buffer_top uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_access(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet > 3000 && !timed_out) begin
      timed_out = 1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= rst_n && !hold_sink && (idle_off || $urandom_range(99) >= 20);

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send(bit cmd, bit [31:0] addr);
    while (!idle_off && $urandom_range(99) < 20) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{command: cmd, address: addr};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic stop_send();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic configure(int ob, int ib, int ws, int vn);
    drain();
    write_reg(sacvb_pkg::REG_OFFSET, 5'(ob));
    write_reg(sacvb_pkg::REG_INDEX, 5'(ib));
    write_reg(sacvb_pkg::REG_WAYS, 5'(ws));
    write_reg(sacvb_pkg::REG_VICTIM, 5'(vn));
    for (int i = 0; i < 8; i++) hot_addr[i] = $urandom();
  endtask

  task automatic random_phase(int n);
    bit [31:0] a;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(3) == 0) a = $urandom();
      else a = hot_addr[$urandom_range(7)] ^ ($urandom_range(15) << $urandom_range(14));
      send(1'($urandom_range(1)), a);
    end
    stop_send();
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Defaults from reset: full-size cache, victim buffer off.
    send(0, 32'h0); send(1, 32'h0); send(1, 32'hFFFF_FFFF); send(0, 32'hFFFF_FFFF);
    stop_send();
    configure(1, 0, 1, 1);
    send(1, 32'h0); send(1, 32'h4); send(0, 32'h0); send(1, 32'h8);
    send(0, 32'h4); send(0, 32'hFFFF_FFFE);
    stop_send();
    configure(12, 2, 2, 2);
    for (int i = 0; i < 6; i++) send(i[0], i * 32'h4000);
    send(0, 32'h0); send(1, 32'h4000);
    stop_send();
    // Out-of-range register values saturate.
    configure(0, 15, 15, 31);
    send(1, 32'hA5A5_5A5A); send(0, 32'h5A5A_A5A5);
    stop_send();
    configure(4, 1, 2, 4);
    idle_off = 1;
    random_phase(100);
    idle_off = 0;
    configure(3, 0, 1, 16);
    random_phase(120);
    configure(5, 8, 8, 0);
    random_phase(100);
    configure(1, 3, 3, 5);
    fork
      random_phase(100);
      begin
        hold_sink = 1;
        repeat (300) @(posedge clk);
        hold_sink = 0;
      end
    join
    configure(12, 8, 8, 16);
    random_phase(100);
    configure(6, 2, 4, 3);
    random_phase(130);
    configure(2, 1, 1, 0);
    random_phase(100);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### filelist.f
hdl/sacvb_pkg.sv
hdl/sacvb_front.sv
hdl/sacvb_back.sv
hdl/set_assoc_cache_with_victim_buffer_top.sv
tb/tb.sv
